[src/rsn_pkg.sv]
// Shared types, sizes and codes for the ring space notification table.
// Used by every module of the block; depends on nothing.
package rsn_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RES     = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W       = 8;

  // Operation codes as they arrive on the command word.
  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_DEQUEUE = 3'd1;
  localparam logic [2:0] OP_COUNT   = 3'd2;
  localparam logic [2:0] OP_LIST    = 3'd3;
  localparam logic [2:0] OP_RING    = 3'd4;
  localparam logic [2:0] OP_POP     = 3'd5;

  typedef enum logic [2:0] {
    K_ENQ, K_DEQ, K_CNT, K_LIST, K_RING, K_POP, K_NONE
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_PRE, ST_SCAN, ST_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] port;
    logic [15:0] domain;
    logic [31:0] callback_id;
    logic [63:0] context_a;
    logic [63:0] context_b;
    logic [31:0] space_needed;
    logic        sufficient;
    logic [4:0]  list_limit;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic        table_full;
    logic        entry_present;
    logic [31:0] out_port;
    logic [15:0] out_domain;
    logic [31:0] out_callback_id;
    logic [63:0] out_context_a;
    logic [63:0] out_context_b;
    logic [31:0] out_space;
    logic [4:0]  tally;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] port;
    logic [15:0] domain;
    logic [31:0] callback;
    logic [63:0] context_a;
    logic [63:0] context_b;
    logic [31:0] space;
  } entry_t;

  typedef struct packed {
    kind_e      kind;
    entry_t     key;
    logic       sufficient;
    logic [4:0] list_limit;
  } job_t;

  // Handshake between the front queue and the back executor.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

endpackage

[src/rsn_front.sv]
// Front part: classifies incoming commands and queues them for the executor.
// Depends on rsn_pkg.
module rsn_front
  import rsn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cmd_t      cmd_i,
  output logic      busy_o,
  output job_chan_t job_o,
  input  logic      pop_i
);

  job_t              q_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pull;
  job_t              job_new;

  // Classify the operation code; unused codes become a no-op job.
  always_comb begin
    job_new.key.port      = cmd_i.port;
    job_new.key.domain    = cmd_i.domain;
    job_new.key.callback  = cmd_i.callback_id;
    job_new.key.context_a = cmd_i.context_a;
    job_new.key.context_b = cmd_i.context_b;
    job_new.key.space     = cmd_i.space_needed;
    job_new.sufficient    = cmd_i.sufficient;
    job_new.list_limit    = cmd_i.list_limit;
    unique case (cmd_i.op)
      OP_ENQUEUE: job_new.kind = K_ENQ;
      OP_DEQUEUE: job_new.kind = K_DEQ;
      OP_COUNT:   job_new.kind = K_CNT;
      OP_LIST:    job_new.kind = K_LIST;
      OP_RING:    job_new.kind = K_RING;
      OP_POP:     job_new.kind = K_POP;
      default:    job_new.kind = K_NONE;
    endcase
  end

  assign busy_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = start_i && !busy_o;
  assign pull        = pop_i && (cnt_q != '0);
  assign job_o.valid = (cnt_q != '0);
  assign job_o.job   = q_q[rd_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pull) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pull) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pull && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= job_new;
    end
  end

endmodule

[src/rsn_back.sv]
// Back part: holds the packed subscription table and walks it one entry a cycle.
// Depends on rsn_pkg.
module rsn_back
  import rsn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_chan_t job_i,
  output logic      pop_o,
  output logic      res_valid_o,
  output res_t      res_o
);

  entry_t           ent_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] fired_q;
  state_e           state_q, state_d;
  job_t             job_q, job_d;
  logic [CNT_W-1:0] n_q, n_d, r_q, r_d, w_q, w_d, cnt_q, cnt_d, k_q, k_d, e_q, e_d;
  logic             found_q, found_d;
  res_t             res_q, res_d;
  logic             vld_q, vld_d;

  // One write port into the table, plus one for the fired marks.
  logic             we;
  logic [IDX_W-1:0] widx;
  entry_t           wdata;
  logic             fwe;
  logic [IDX_W-1:0] fidx;
  logic             fval;

  entry_t           cur;
  logic             cur_f;
  logic             key_m, pd_m, last_r, can_emit;
  logic [CMP_W-1:0] kmin;
  logic [CNT_W-1:0] cnt_nx;

  function automatic logic [4:0] sat5(input logic [CNT_W-1:0] v);
    logic [CMP_W-1:0] x;
    x = CMP_W'(v);
    return (x > CMP_W'(31)) ? 5'd31 : x[4:0];
  endfunction

  assign cur    = ent_q[r_q[IDX_W-1:0]];
  assign cur_f  = fired_q[r_q[IDX_W-1:0]];
  assign pd_m   = (cur.port == job_q.key.port) && (cur.domain == job_q.key.domain);
  assign key_m  = pd_m && (cur.callback == job_q.key.callback) &&
                  (cur.context_a == job_q.key.context_a) &&
                  (cur.context_b == job_q.key.context_b);
  assign last_r = (r_q == n_q - 1'b1);
  assign can_emit = (e_q < k_q);

  // Pre-pass tally: unfired entries for list, fired ones for pop.
  assign cnt_nx = cnt_q + CNT_W'((job_q.kind == K_LIST) ? !cur_f : cur_f);

  // Emission budget for the second pass.
  always_comb begin
    kmin = CMP_W'(cnt_nx);
    if (job_q.kind == K_LIST && CMP_W'(job_q.list_limit) < kmin) begin
      kmin = CMP_W'(job_q.list_limit);
    end
    if (kmin > CMP_W'(MAX_RES)) begin
      kmin = CMP_W'(MAX_RES);
    end
  end

  // Sequencer: next state, table writes and result word.
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    n_d     = n_q;
    r_d     = r_q;
    w_d     = w_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    e_d     = e_q;
    found_d = found_q;
    res_d   = '0;
    vld_d   = 1'b0;
    pop_o   = 1'b0;
    we      = 1'b0;
    widx    = w_q[IDX_W-1:0];
    wdata   = cur;
    fwe     = 1'b0;
    fidx    = w_q[IDX_W-1:0];
    fval    = cur_f;

    unique case (state_q)
      ST_IDLE: begin
        if (job_i.valid) begin
          pop_o   = 1'b1;
          job_d   = job_i.job;
          r_d     = '0;
          w_d     = '0;
          cnt_d   = '0;
          k_d     = '0;
          e_d     = '0;
          found_d = 1'b0;
          if (job_i.job.kind == K_NONE || n_q == '0) begin
            state_d = ST_FINISH;
          end else if (job_i.job.kind == K_LIST || job_i.job.kind == K_POP) begin
            state_d = ST_PRE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_PRE: begin
        cnt_d = cnt_nx;
        r_d   = r_q + 1'b1;
        if (last_r) begin
          k_d = kmin[CNT_W-1:0];
          r_d = '0;
          state_d = (kmin == '0) ? ST_FINISH : ST_SCAN;
        end
      end

      ST_SCAN: begin
        unique case (job_q.kind)
          K_ENQ: begin
            if (key_m) begin
              we          = 1'b1;
              widx        = r_q[IDX_W-1:0];
              wdata.space = job_q.key.space;
              fwe         = 1'b1;
              fidx        = r_q[IDX_W-1:0];
              fval        = 1'b0;
              found_d     = 1'b1;
            end
          end
          K_DEQ: begin
            if (key_m) begin
              found_d = 1'b1;
            end else begin
              we  = 1'b1;
              fwe = 1'b1;
              w_d = w_q + 1'b1;
            end
          end
          K_CNT: begin
            if (!cur_f) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          K_RING: begin
            if (job_q.sufficient && pd_m) begin
              fwe     = 1'b1;
              fidx    = r_q[IDX_W-1:0];
              fval    = 1'b1;
              found_d = 1'b1;
            end
          end
          K_LIST: begin
            if (!cur_f && can_emit) begin
              vld_d               = 1'b1;
              res_d.entry_present = 1'b1;
              res_d.out_port      = cur.port;
              res_d.out_domain    = cur.domain;
              res_d.out_space     = cur.space;
              res_d.tally         = sat5(k_q);
              res_d.last          = (e_q + 1'b1 == k_q);
              e_d                 = e_q + 1'b1;
            end
          end
          K_POP: begin
            if (cur_f && can_emit) begin
              vld_d               = 1'b1;
              res_d.entry_present = 1'b1;
              res_d.out_port      = cur.port;
              res_d.out_domain    = cur.domain;
              res_d.out_callback_id = cur.callback;
              res_d.out_context_a = cur.context_a;
              res_d.out_context_b = cur.context_b;
              res_d.last          = (e_q + 1'b1 == k_q);
              e_d                 = e_q + 1'b1;
            end else begin
              we  = 1'b1;
              fwe = 1'b1;
              w_d = w_q + 1'b1;
            end
          end
          default: begin
          end
        endcase
        r_d = r_q + 1'b1;
        if (last_r) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        state_d    = ST_IDLE;
        res_d.last = 1'b1;
        unique case (job_q.kind)
          K_ENQ: begin
            vld_d           = 1'b1;
            res_d.hit       = found_q;
            res_d.table_full = !found_q && (n_q == CNT_W'(TABLE_DEPTH));
            if (!found_q && n_q != CNT_W'(TABLE_DEPTH)) begin
              we    = 1'b1;
              widx  = n_q[IDX_W-1:0];
              wdata = job_q.key;
              fwe   = 1'b1;
              fidx  = n_q[IDX_W-1:0];
              fval  = 1'b0;
              n_d   = n_q + 1'b1;
            end
          end
          K_DEQ: begin
            vld_d     = 1'b1;
            res_d.hit = found_q;
            n_d       = w_q;
          end
          K_CNT: begin
            vld_d       = 1'b1;
            res_d.tally = sat5(cnt_q);
          end
          K_RING: begin
            vld_d     = 1'b1;
            res_d.hit = found_q;
          end
          K_LIST: begin
            vld_d = (k_q == '0);
          end
          K_POP: begin
            vld_d = (k_q == '0);
            if (k_q != '0) begin
              n_d = w_q;
            end
          end
          default: begin
            vld_d = 1'b1;
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      r_q     <= '0;
      w_q     <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      e_q     <= '0;
      found_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      r_q     <= r_d;
      w_q     <= w_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      e_q     <= e_d;
      found_q <= found_d;
      vld_q   <= vld_d;
    end
  end

  // Table contents, the held job and the result word carry no reset.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_q <= res_d;
    if (we) begin
      ent_q[widx] <= wdata;
    end
    if (fwe) begin
      fired_q[fidx] <= fval;
    end
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

[src/ring_space_notify_table.sv]
// Ring space notification table, top level: front queue plus table executor.
// Commands walk the table entry by entry; list and pop walk it twice.
// The executor handles one command at a time, set by the single-entry table
// walk; a 2-word queue absorbs bursts. Results come at most one per cycle
// and cannot be stalled.
// Reset empties the table and the queue; entry contents are left as they are.
module ring_space_notify_table
  import rsn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  job_chan_t job;
  logic      pop;

  rsn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .job_o   (job),
    .pop_i   (pop)
  );

  rsn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[src/rsn_checker.sv]
// Port-level checks for the ring space notification table, bound to the top.
// Depends on rsn_pkg and ring_space_notify_table.
module rsn_checker
  import rsn_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input cmd_t cmd_i,
  input logic busy_o,
  input logic res_valid_o,
  input res_t res_o
);

  // No result word leaves the block in the cycle after reset ends.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !res_valid_o)
    else $error("result word right after reset");

  // A word without an entry is always the only word of its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.entry_present |-> res_o.last)
    else $error("entry-less word not marked last");

  // Full and hit never come together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.hit && res_o.table_full))
    else $error("hit and table full together");

  // An emitted entry never reports a list size above the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.entry_present |-> res_o.tally <= 5'(TABLE_DEPTH))
    else $error("list tally beyond table depth");

  // A word right after a non-final word belongs to the same list or pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> !res_valid_o || res_o.entry_present)
    else $error("other word inside a multi-word result");

endmodule

bind ring_space_notify_table rsn_checker u_rsn_checker (.*);
